### hdl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types, register indexes and helpers for the stream find-and-replace
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int DEF_MAX_PATTERN     = 8;
  localparam int DEF_MAX_REPLACEMENT = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RELEASE,
    ST_DECIDE,
    ST_REPL,
    ST_TAIL,
    ST_FIN
  } sfr_state_t;

  // one event from the sequencer to the output stage
  typedef struct packed {
    logic       push;
    logic       finish;
    logic       last;
    logic [7:0] data;
  } sfr_emit_t;

  // byte i of a 64-bit word, zero for i of 8 or more
  function automatic logic [7:0] byte_at(logic [63:0] word, logic [5:0] i);
    logic [7:0] b;
    b = 8'd0;
    if (i < 6'd8) begin
      b = word[{i[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

### hdl/sfr_out.sv
// ----------------------------------------------------------------------------
// sfr_out
// output stage: one-item hold slot so the final item of a text can be marked,
// followed by the output register
// ----------------------------------------------------------------------------
module sfr_out
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sfr_emit_t  emit,
  output logic       stage_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last_of_text
);

  logic       hold_v_r;
  logic [7:0] hold_byte_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_bval_r;
  logic       out_last_r;

  assign stage_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit.push && stage_ready) begin
        if (hold_v_r) begin
          out_valid_r <= 1'b1;
          out_byte_r  <= hold_byte_r;
          out_bval_r  <= 1'b1;
          out_last_r  <= 1'b0;
        end
        hold_v_r    <= 1'b1;
        hold_byte_r <= emit.data;
      end else if (emit.finish && stage_ready) begin
        if (hold_v_r) begin
          out_valid_r <= 1'b1;
          out_byte_r  <= hold_byte_r;
          out_bval_r  <= 1'b1;
          out_last_r  <= emit.last;
          hold_v_r    <= 1'b0;
        end else if (emit.last) begin
          // empty end marker
          out_valid_r <= 1'b1;
          out_byte_r  <= 8'd0;
          out_bval_r  <= 1'b0;
          out_last_r  <= 1'b1;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_byte_valid   = out_bval_r;
  assign out_last_of_text = out_last_r;

endmodule

### hdl/sfr_seq.sv
// ----------------------------------------------------------------------------
// sfr_seq
// sequencer with the pending buffer and one shared byte comparator; checks
// the pending bytes against the pattern one byte a cycle and issues releases,
// replacement bytes and the end-of-text flush
// ----------------------------------------------------------------------------
module sfr_seq
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_text,
  input  logic [3:0]  pattern_length,
  input  logic [63:0] pattern_bytes,
  input  logic [3:0]  replacement_length,
  input  logic [63:0] replacement_bytes,
  input  logic        stage_ready,
  output sfr_emit_t   emit
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int RL_W  = $clog2(MAX_REPLACEMENT + 1);

  sfr_state_t state_r, state_nxt;

  logic [7:0]       pend_r [MAX_PATTERN];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [RL_W-1:0]  ridx_r, ridx_nxt;
  logic             last_r, last_nxt;

  logic             accept;
  logic             shift;
  logic [CNT_W-1:0] plen;
  logic [RL_W-1:0]  rlen;
  logic [31:0]      plen32;
  logic [31:0]      rlen32;
  logic             byte_eq;

  always_comb begin
    plen32 = 32'(pattern_length);
    if (plen32 == 32'd0) begin
      plen32 = 32'd1;
    end
    if (plen32 > 32'(MAX_PATTERN)) begin
      plen32 = 32'(MAX_PATTERN);
    end
    rlen32 = 32'(replacement_length);
    if (rlen32 > 32'(MAX_REPLACEMENT)) begin
      rlen32 = 32'(MAX_REPLACEMENT);
    end
  end

  assign plen = plen32[CNT_W-1:0];
  assign rlen = rlen32[RL_W-1:0];

  // shared comparator
  assign byte_eq = (pend_r[idx_r[IDX_W-1:0]] == byte_at(pattern_bytes, 6'(idx_r)));

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      ridx_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      ridx_r  <= ridx_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r[cnt_r[IDX_W-1:0]] <= in_byte;
    end else if (shift) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        pend_r[i] <= pend_r[i+1];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    ridx_nxt  = ridx_r;
    last_nxt  = last_r;
    shift     = 1'b0;
    in_ready  = 1'b0;
    emit      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          idx_nxt   = '0;
          last_nxt  = in_end_of_text;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cnt_r > plen) begin
          state_nxt = ST_RELEASE;
        end else if (idx_r == cnt_r) begin
          state_nxt = ST_DECIDE;
        end else if (byte_eq) begin
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          state_nxt = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (stage_ready) begin
          emit.push = 1'b1;
          emit.data = pend_r[0];
          shift     = 1'b1;
          cnt_nxt   = cnt_r - CNT_W'(1);
          idx_nxt   = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_DECIDE: begin
        ridx_nxt = '0;
        if (cnt_r == plen) begin
          cnt_nxt   = '0;
          state_nxt = (rlen != '0) ? ST_REPL : ST_TAIL;
        end else begin
          state_nxt = ST_TAIL;
        end
      end
      ST_REPL: begin
        if (stage_ready) begin
          emit.push = 1'b1;
          emit.data = byte_at(replacement_bytes, 6'(ridx_r));
          ridx_nxt  = ridx_r + RL_W'(1);
          if (RL_W'(ridx_r + RL_W'(1)) == rlen) begin
            state_nxt = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (last_r && (cnt_r != '0)) begin
          if (stage_ready) begin
            emit.push = 1'b1;
            emit.data = pend_r[0];
            shift     = 1'b1;
            cnt_nxt   = cnt_r - CNT_W'(1);
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stage_ready) begin
          emit.finish = 1'b1;
          emit.last   = last_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/stream_find_and_replace_core.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace_core
// Streaming find-and-replace-all over a byte text, one byte per input item.
// Every leftmost non-overlapping occurrence of the configured pattern is
// replaced by the configured replacement; all other bytes pass in order.
// Bytes that may still start a match wait in a pending buffer. One byte
// comparator checks the pending bytes against the pattern one per cycle; on a
// mismatch the oldest byte is released and the check restarts. An item goes
// through accept, the check passes, decide, the replacement bytes on a match,
// tail and close; each result item emitted may wait on a full output
// register. A check pass compares bytes up to the first mismatch and ends at
// once when the buffer is longer than the pattern; a pass runs after the
// accept and again after every release. The input is not ready while an item
// is worked on. Results pass through a one-item hold slot, so the final item
// of a text carries the last flag; an end with nothing to emit gives one empty
// item with byte_valid low. Configuration must be written only while idle;
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
module stream_find_and_replace_core
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_end_of_text,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_byte_valid,
  output logic                  out_last_of_text
);

  logic [3:0]  pattern_length_r;
  logic [63:0] pattern_bytes_r;
  logic [3:0]  replacement_length_r;
  logic [63:0] replacement_bytes_r;

  sfr_emit_t emit;
  logic      stage_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r     <= 4'd1;
      pattern_bytes_r      <= '0;
      replacement_length_r <= 4'd0;
      replacement_bytes_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH:     pattern_length_r     <= cfg_wdata[3:0];
        REG_PATTERN_BYTES:      pattern_bytes_r      <= cfg_wdata;
        REG_REPLACEMENT_LENGTH: replacement_length_r <= cfg_wdata[3:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  sfr_seq #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .in_end_of_text     (in_end_of_text),
    .pattern_length     (pattern_length_r),
    .pattern_bytes      (pattern_bytes_r),
    .replacement_length (replacement_length_r),
    .replacement_bytes  (replacement_bytes_r),
    .stage_ready        (stage_ready),
    .emit               (emit)
  );

  sfr_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .emit             (emit),
    .stage_ready      (stage_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last_of_text (out_last_of_text)
  );

endmodule

### tb/sv/sfr_text_checker.sv
// ----------------------------------------------------------------------------
// sfr_text_checker
// Watches the configuration port and both item channels of the stream
// find-and-replace core, keeps its own copy of the registers and of the
// pending bytes, works out the rewritten text for every accepted input item
// and compares every accepted result item field by field, in order.
// ----------------------------------------------------------------------------
module sfr_text_checker
  import sfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_end_of_text,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_byte,
  input  logic                  out_byte_valid,
  input  logic                  out_last_of_text,
  output int                    fail_count,
  output int                    expected_count,
  output int                    results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAT_MAX  = DEF_MAX_PATTERN;
  localparam int REP_MAX  = DEF_MAX_REPLACEMENT;
  localparam int STEP_MAX = 2 * PAT_MAX + REP_MAX + 1;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
  } text_out_t;

  logic [3:0]  pat_len_reg;
  logic [63:0] pat_word;
  logic [3:0]  rep_len_reg;
  logic [63:0] rep_word;

  logic [7:0]  held [PAT_MAX];
  int          held_n;
  text_out_t   step_out [STEP_MAX];
  int          step_n;
  text_out_t   rewritten_q [$];

  function automatic int pattern_span();
    int n;
    n = int'(pat_len_reg);
    if (n < 1) n = 1;
    if (n > PAT_MAX) n = PAT_MAX;
    return n;
  endfunction

  function automatic int replacement_span();
    int n;
    n = int'(rep_len_reg);
    if (n > REP_MAX) n = REP_MAX;
    return n;
  endfunction

  function automatic logic held_is_prefix(int plen);
    logic ok;
    ok = (held_n <= plen);
    for (int i = 0; i < held_n && ok; i++) begin
      if (held[i] != pat_word[8*i +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void put_result(logic [7:0] d, logic v);
    step_out[step_n] = '{data: d, byte_valid: v, last: 1'b0};
    step_n++;
  endfunction

  function automatic void release_oldest();
    put_result(held[0], 1'b1);
    for (int i = 1; i < held_n; i++) begin
      held[i-1] = held[i];
    end
    held_n--;
  endfunction

  // rewritten text caused by one input byte
  function automatic void rewrite_byte(logic [7:0] b, logic eot);
    int plen;
    int rlen;
    plen   = pattern_span();
    step_n = 0;
    if (held_n >= PAT_MAX) release_oldest();
    held[held_n] = b;
    held_n++;
    while (held_n > 0 && !held_is_prefix(plen)) begin
      release_oldest();
    end
    if (held_n == plen) begin
      rlen = replacement_span();
      for (int i = 0; i < rlen; i++) begin
        put_result(rep_word[8*i +: 8], 1'b1);
      end
      held_n = 0;
    end
    if (eot) begin
      for (int i = 0; i < held_n; i++) begin
        put_result(held[i], 1'b1);
      end
      held_n = 0;
      if (step_n == 0) put_result(8'h00, 1'b0);
      step_out[step_n-1].last = 1'b1;
    end
    for (int i = 0; i < step_n; i++) begin
      rewritten_q.push_back(step_out[i]);
    end
  endfunction

  always @(posedge clk) begin
    text_out_t exp_r;
    if (!rst_n) begin
      pat_len_reg = 4'd1;
      pat_word    = '0;
      rep_len_reg = 4'd0;
      rep_word    = '0;
      held_n      = 0;
      rewritten_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_LENGTH:     pat_len_reg = cfg_wdata[3:0];
          REG_PATTERN_BYTES:      pat_word    = cfg_wdata;
          REG_REPLACEMENT_LENGTH: rep_len_reg = cfg_wdata[3:0];
          REG_REPLACEMENT_BYTES:  rep_word    = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (rewritten_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result item, expected none, actual byte %02h valid %0b last %0b",
                   $time, out_byte, out_byte_valid, out_last_of_text);
        end else begin
          exp_r = rewritten_q.pop_front();
          if (out_byte !== exp_r.data) begin
            fail_count++;
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, exp_r.data, out_byte);
          end
          if (out_byte_valid !== exp_r.byte_valid) begin
            fail_count++;
            $display("%0t: out_byte_valid expected %0b actual %0b",
                     $time, exp_r.byte_valid, out_byte_valid);
          end
          if (out_last_of_text !== exp_r.last) begin
            fail_count++;
            $display("%0t: out_last_of_text expected %0b actual %0b",
                     $time, exp_r.last, out_last_of_text);
          end
        end
      end
      if (in_valid && in_ready) rewrite_byte(in_byte, in_end_of_text);
    end
    expected_count = rewritten_q.size();
  end

endmodule

### tb/sv/tb_stream_find_and_replace_core.sv
// ----------------------------------------------------------------------------
// tb_stream_find_and_replace_core
// Drives byte texts into the find-and-replace core with random gaps and
// result stalls, across many pattern and replacement settings including
// clamped lengths and changes in the middle of a text; the checker beside
// the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_stream_find_and_replace_core
  import sfr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 100;
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_ITEMS  = 500;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_byte;
  logic                  in_end_of_text;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;
  logic                  out_byte_valid;
  logic                  out_last_of_text;

  int fail_count;
  int expected_count;
  int results_checked;
  int items_sent;
  int texts_sent;
  int reg_writes;
  int idle_cycles;
  bit in_fast;
  bit out_fast;

  stream_find_and_replace_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last_of_text (out_last_of_text)
  );

  sfr_text_checker text_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last_of_text (out_last_of_text),
    .fail_count       (fail_count),
    .expected_count   (expected_count),
    .results_checked  (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap(bit fast);
    return fast ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [3:0] draw_len();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(1, 8));
  endfunction

  task automatic send_item(logic [7:0] b, logic eot);
    int gap;
    gap = draw_gap(in_fast);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_byte        = b;
    in_end_of_text = eot;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    if (eot) texts_sent++;
  endtask

  task automatic send_text(logic [7:0] text_q [$]);
    for (int i = 0; i < text_q.size(); i++) begin
      send_item(text_q[i], i == text_q.size() - 1);
    end
  endtask

  // block drained and quiet before any register write
  task automatic settle();
    in_valid = 1'b0;
    while (expected_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    reg_writes++;
  endtask

  task automatic load_setup(logic [3:0] pl, logic [63:0] pw, logic [3:0] rl, logic [63:0] rw);
    settle();
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(pl));
    write_reg(REG_PATTERN_BYTES, pw);
    write_reg(REG_REPLACEMENT_LENGTH, CFG_DATA_W'(rl));
    write_reg(REG_REPLACEMENT_BYTES, rw);
  endtask

  // result side stalls
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap(out_fast);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [3:0]           pl;
    logic [3:0]           rl;
    logic [63:0]          pw;
    logic [63:0]          rw;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] val;
    logic [7:0]           text_q [$];
    bit                   narrow;
    int                   plen;
    int                   len;
    int                   k;
    int                   r;
    int                   item_goal;
    int                   setups;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_PATTERN_LENGTH;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    in_end_of_text = 1'b0;
    in_fast        = 1'b0;
    out_fast       = 1'b0;
    setups         = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // reset settings delete zero bytes
    send_text('{8'h00, 8'hff, 8'h00});

    // failed attempt, match and flush of a partial match at the end
    load_setup(4'd3, 64'h636261, 4'd2, 64'h5958);
    send_text('{8'h61, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62});

    // pattern changed under pending bytes
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    settle();
    write_reg(REG_PATTERN_BYTES, 64'h637861);
    send_item(8'h63, 1'b1);

    // zero pattern length, then an empty end marker, then clamped replacement
    load_setup(4'd0, 64'hff, 4'd0, 64'h0);
    send_text('{8'hff});
    settle();
    write_reg(REG_REPLACEMENT_LENGTH, 64'd15);
    write_reg(REG_REPLACEMENT_BYTES, 64'h0123456789abcdef);
    send_text('{8'h80, 8'hff});

    // clamped pattern length, long partial match released
    load_setup(4'd15, 64'hfedcba9876543210, 4'd8, 64'hffffffffffffffff);
    send_text('{8'h10, 8'h32, 8'h54, 8'h10, 8'h32, 8'h54, 8'h76, 8'h98,
                8'hba, 8'hdc, 8'hfe});
    setups = 4;

    item_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < item_goal) begin
      pl     = draw_len();
      rl     = draw_len();
      narrow = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 8; i++) begin
        pw[8*i +: 8] = narrow ? 8'(8'h61 + $urandom_range(0, 1)) : 8'($urandom_range(0, 255));
      end
      rw = {$urandom, $urandom};
      load_setup(pl, pw, rl, rw);
      setups++;
      in_fast  = ($urandom_range(0, 3) == 0);
      out_fast = ($urandom_range(0, 3) == 0);
      plen = (pl == 4'd0) ? 1 : ((pl > 4'd8) ? 8 : int'(pl));

      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 24);
        text_q.delete();
        while (text_q.size() < len) begin
          r = $urandom_range(0, 9);
          if (r < 5) begin
            for (int i = 0; i < plen; i++) text_q.push_back(pw[8*i +: 8]);
          end else if (r < 7) begin
            k = $urandom_range(1, plen);
            for (int i = 0; i < k; i++) text_q.push_back(pw[8*i +: 8]);
          end else if (narrow && r < 9) begin
            text_q.push_back(8'(8'h61 + $urandom_range(0, 2)));
          end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        while (text_q.size() > len) void'(text_q.pop_back());

        for (int i = 0; i < len; i++) begin
          send_item(text_q[i], i == len - 1);
          if (i != len - 1 && $urandom_range(0, 39) == 0) begin
            // register rewrite in the middle of a text
            settle();
            idx = CFG_IDX_W'($urandom_range(0, 3));
            if (idx == REG_PATTERN_LENGTH || idx == REG_REPLACEMENT_LENGTH) begin
              val = CFG_DATA_W'($urandom_range(0, 15));
            end else begin
              val = {$urandom, $urandom};
            end
            write_reg(idx, val);
          end
        end
      end
    end

    in_valid = 1'b0;
    while (expected_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d input items in %0d texts under %0d settings, %0d register writes",
             items_sent, texts_sent, setups, reg_writes);
    $display("%0d result items compared, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0 && expected_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
